@@ rtl/qs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qs_pkg: shared definitions of the quicksort sorter
// Data widths, the default capacity and the sequencer state type.
// ----------------------------------------------------------------------------
package qs_pkg;

  // Width of one element and of one sorted result.
  localparam int unsigned VALUE_W = 32;

  // Default capacity of the element buffer.
  localparam int unsigned MAX_ELEMENTS_DEF = 64;

  // Sequencer states: load, partition passes, range stack and drain.
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_START,
    ST_POP,
    ST_RANGE,
    ST_PIV_A,
    ST_PIV_B,
    ST_SCAN,
    ST_CMP,
    ST_SWP_A,
    ST_SWP_B,
    ST_FIN_A,
    ST_FIN_B,
    ST_EMIT_RD,
    ST_EMIT_LD
  } qs_state_e;

endpackage
`default_nettype wire

@@ rtl/qs_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qs_if: stream channels of the quicksort sorter
// Element channel into the sorter and result channel out of it, each with a
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface qs_in_if;
  import qs_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               final_item;

  modport source (output valid, output value, output final_item, input ready);
  modport sink   (input valid, input value, input final_item, output ready);
endinterface

interface qs_out_if;
  import qs_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] sorted_value;
  logic               end_of_run;
  logic               dropped;

  modport source (output valid, output sorted_value, output end_of_run,
                  output dropped, input ready);
  modport sink   (input valid, input sorted_value, input end_of_run,
                  input dropped, output ready);
endinterface
`default_nettype wire

@@ rtl/qs_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qs_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module qs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ rtl/quicksort_sorter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quicksort_sorter: buffered in-place quicksort of a set of signed integers
// Collects elements into a RAM, sorts them by quicksort with a middle pivot
// and a stack of pending ranges, then streams them out in ascending order.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Beat contents                         Accepted when
//   in_i     in   value, final_item                     valid && ready
//   out_o    out  sorted_value, end_of_run, dropped     valid && ready
//
// Elements load at one beat per cycle; the closing beat starts the sort in the element RAM.
// A partition pass reads the pivot, scans the range and swaps pairs, and a range is popped between passes,
// all through the single read port and the single write port of the RAM.
// The drain then reads each result from the RAM and loads it into the result register.
// Reset clears the sequencer only; the RAM needs no clearing pass. A stall on out_o holds the
// result register and pauses the drain; in_i is ready once the last result is registered.
// ----------------------------------------------------------------------------
module quicksort_sorter #(
  parameter int unsigned MAX_ELEMENTS = qs_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  qs_in_if.sink     in_i,
  qs_out_if.source  out_o
);
  import qs_pkg::*;

  localparam int unsigned IW  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CW  = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned STK = IW + 1;
  localparam int unsigned SW  = $clog2(STK);
  localparam int unsigned SPW = $clog2(STK + 1);

  qs_state_e state_q, state_d;

  logic [CW-1:0]  count_q, count_d;
  logic           ovf_q, ovf_d;
  logic [IW-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [IW-1:0]  i_q, i_d, place_q, place_d, k_q, k_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic signed [VALUE_W-1:0] pivot_q, pivot_d, val_q, val_d;

  logic [IW-1:0] stk_lo_q [STK];
  logic [IW-1:0] stk_hi_q [STK];
  logic          push_en;
  logic [IW-1:0] push_lo, push_hi;
  logic [SPW-1:0] sp_m1;

  logic                out_valid_q, out_valid_d;
  logic [VALUE_W-1:0]  out_value_q;
  logic                out_last_q, out_drop_q;
  logic                out_load, out_last_d;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr, ram_raddr;
  logic [VALUE_W-1:0]  ram_wdata, ram_rdata;

  logic          in_fire;
  logic [IW-1:0] mid, left_n, right_n;

  // Element RAM holding the set, sorted in place.
  qs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Handshake and range arithmetic.
  assign in_i.ready = (state_q == ST_LOAD);
  assign in_fire    = in_i.valid && in_i.ready;
  assign mid        = lo_q + ((hi_q - lo_q) >> 1);
  assign left_n     = place_q - lo_q;
  assign right_n    = hi_q - place_q;
  assign sp_m1      = sp_q - SPW'(1);
  assign out_last_d = ((CW'(k_q) + CW'(1)) == count_q);

  // Output register toward the result channel.
  assign out_o.valid        = out_valid_q;
  assign out_o.sorted_value = out_value_q;
  assign out_o.end_of_run   = out_last_q;
  assign out_o.dropped      = out_drop_q;

  // Next state and datapath control of the sort sequencer.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    i_d       = i_q;
    place_d   = place_q;
    k_d       = k_q;
    sp_d      = sp_q;
    pivot_d   = pivot_q;
    val_d     = val_q;
    push_en   = 1'b0;
    push_lo   = lo_q;
    push_hi   = hi_q;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = i_q;
    ram_wdata = ram_rdata;
    ram_raddr = k_q;

    case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (count_q < CW'(MAX_ELEMENTS)) begin
            ram_we    = 1'b1;
            ram_waddr = count_q[IW-1:0];
            ram_wdata = in_i.value;
            count_d   = count_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_i.final_item) begin
            state_d = ST_START;
          end
        end
      end

      ST_START: begin
        sp_d = '0;
        k_d  = '0;
        if (count_q > CW'(1)) begin
          lo_d    = '0;
          hi_d    = IW'(count_q - CW'(1));
          state_d = ST_RANGE;
        end else begin
          state_d = ST_EMIT_RD;
        end
      end

      // Take the next pending range, or drain when none is left.
      ST_POP: begin
        if (sp_q == '0) begin
          k_d     = '0;
          state_d = ST_EMIT_RD;
        end else begin
          lo_d    = stk_lo_q[sp_m1[SW-1:0]];
          hi_d    = stk_hi_q[sp_m1[SW-1:0]];
          sp_d    = sp_m1;
          state_d = ST_RANGE;
        end
      end

      ST_RANGE: begin
        ram_raddr = mid;
        state_d   = ST_PIV_A;
      end

      ST_PIV_A: begin
        pivot_d   = ram_rdata;
        ram_raddr = hi_q;
        state_d   = ST_PIV_B;
      end

      // The pivot stays in a register; the top entry moves to the middle.
      ST_PIV_B: begin
        ram_we    = 1'b1;
        ram_waddr = mid;
        ram_wdata = ram_rdata;
        i_d       = lo_q;
        place_d   = lo_q;
        state_d   = ST_SCAN;
      end

      ST_SCAN: begin
        if (i_q == hi_q) begin
          ram_raddr = place_q;
          state_d   = ST_FIN_A;
        end else begin
          ram_raddr = i_q;
          state_d   = ST_CMP;
        end
      end

      ST_CMP: begin
        val_d = ram_rdata;
        if ($signed(ram_rdata) < pivot_q) begin
          if (i_q == place_q) begin
            i_d     = i_q + IW'(1);
            place_d = place_q + IW'(1);
            state_d = ST_SCAN;
          end else begin
            ram_raddr = place_q;
            state_d   = ST_SWP_A;
          end
        end else begin
          i_d     = i_q + IW'(1);
          state_d = ST_SCAN;
        end
      end

      ST_SWP_A: begin
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = ram_rdata;
        state_d   = ST_SWP_B;
      end

      ST_SWP_B: begin
        ram_we    = 1'b1;
        ram_waddr = place_q;
        ram_wdata = val_q;
        i_d       = i_q + IW'(1);
        place_d   = place_q + IW'(1);
        state_d   = ST_SCAN;
      end

      ST_FIN_A: begin
        ram_we    = 1'b1;
        ram_waddr = hi_q;
        ram_wdata = ram_rdata;
        state_d   = ST_FIN_B;
      end

      // Pivot lands at its place; push the larger side, keep the smaller.
      ST_FIN_B: begin
        ram_we    = 1'b1;
        ram_waddr = place_q;
        ram_wdata = pivot_q;
        state_d   = ST_POP;
        if (left_n > right_n) begin
          if (left_n > IW'(1) && sp_q < SPW'(STK)) begin
            push_en = 1'b1;
            push_lo = lo_q;
            push_hi = place_q - IW'(1);
            sp_d    = sp_q + SPW'(1);
          end
          if (right_n > IW'(1)) begin
            lo_d    = place_q + IW'(1);
            state_d = ST_RANGE;
          end
        end else begin
          if (right_n > IW'(1) && sp_q < SPW'(STK)) begin
            push_en = 1'b1;
            push_lo = place_q + IW'(1);
            push_hi = hi_q;
            sp_d    = sp_q + SPW'(1);
          end
          if (left_n > IW'(1)) begin
            hi_d    = place_q - IW'(1);
            state_d = ST_RANGE;
          end
        end
      end

      // Drain: read once the output register is free, then load it.
      ST_EMIT_RD: begin
        ram_raddr = k_q;
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_EMIT_LD;
        end
      end

      ST_EMIT_LD: begin
        out_load = 1'b1;
        if (out_last_d) begin
          count_d = '0;
          ovf_d   = 1'b0;
          state_d = ST_LOAD;
        end else begin
          k_d     = k_q + IW'(1);
          state_d = ST_EMIT_RD;
        end
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Output valid follows loads and accepted beats.
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Range bounds, scan pointers and payload registers.
  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    i_q     <= i_d;
    place_q <= place_d;
    k_q     <= k_d;
    pivot_q <= pivot_d;
    val_q   <= val_d;
    if (push_en) begin
      stk_lo_q[sp_q[SW-1:0]] <= push_lo;
      stk_hi_q[sp_q[SW-1:0]] <= push_hi;
    end
    if (out_load) begin
      out_value_q <= ram_rdata;
      out_last_q  <= out_last_d;
      out_drop_q  <= ovf_q;
    end
  end

`ifndef SYNTHESIS
  // The element count never exceeds the buffer capacity.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ELEMENTS))
    else $error("element count above capacity");

  // A partition pass only starts on a range of at least two elements.
  a_range_size : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RANGE) |-> (lo_q < hi_q))
    else $error("partition range with fewer than two elements");

  // During a scan the pointers stay ordered inside the range.
  a_scan_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (lo_q <= place_q && place_q <= i_q && i_q <= hi_q))
    else $error("scan pointers out of order");

  // The range stack is deep enough that no push is ever skipped.
  a_stack_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN_B) |-> (sp_q < SPW'(STK)))
    else $error("range stack full at a partition end");

  // The last result of a set hands the input back to the load state.
  a_last_reload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_LD && out_last_d) |=> (state_q == ST_LOAD && count_q == '0))
    else $error("set not closed after its last result");
`endif

endmodule
`default_nettype wire
